@@ rtl/wmm_pkg.sv @@
`timescale 1ns / 1ps

package wmm_pkg;

	localparam int MAX_PATTERN = 32;

	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_QMARK = 8'h3f;
	localparam logic [7:0] CH_ESC   = 8'h5c;

	typedef enum logic [1:0] {
		KIND_LITERAL = 2'd0,
		KIND_ANY_ONE = 2'd1,
		KIND_ANY_RUN = 2'd2
	} kind_t;

	typedef struct packed {
		logic       func;
		logic [7:0] char_code;
		logic       last;
		logic       no_char;
	} req_t;

	typedef struct packed {
		logic matched;
		logic pattern_error;
	} rsp_t;

endpackage

@@ rtl/wmm_if.sv @@
`timescale 1ns / 1ps

interface wmm_req_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] char_code;
	logic       last;
	logic       no_char;

	modport source (output valid, func, char_code, last, no_char, input ready);
	modport sink (input valid, func, char_code, last, no_char, output ready);
endinterface

interface wmm_rsp_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_error;

	modport source (output valid, matched, pattern_error, input ready);
	modport sink (input valid, matched, pattern_error, output ready);
endinterface

@@ rtl/wildcard_mask_matcher_core.sv @@
`timescale 1ns / 1ps
// request register, then match logic into the result register; a full one stalls a name's end
// throughput otherwise: one request per cycle, pattern bytes and name bytes alike
// a name byte updates every mask position in parallel, runs of '*' close through one carry chain
// reset: empty mask, no name in progress, both pipeline registers empty
// the mask store itself is not cleared, only positions below the current length are used
module wildcard_mask_matcher_core #(
	parameter int MAX_PATTERN = wmm_pkg::MAX_PATTERN
) (
	input  logic          clk,
	input  logic          arst_n,
	wmm_req_if.sink       req,
	wmm_rsp_if.source     rsp
);

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// request stage
	logic          v_s1;
	wmm_pkg::req_t req_s1;

	// mask store
	logic [7:0]      byte_q [MAX_PATTERN];
	wmm_pkg::kind_t  kind_q [MAX_PATTERN];

	// matcher state
	logic [LW-1:0]        len_q;
	logic                 esc_q;
	logic                 ovf_q;
	logic                 closed_q;
	logic                 name_q;
	logic                 had_q;
	logic [MAX_PATTERN:0] active_q;
	logic [MAX_PATTERN:0] init_q;

	// result register
	logic          out_v_q;
	wmm_pkg::rsp_t out_q;

	logic res_item;
	logic out_free;
	logic go;

	// pattern path
	logic [LW-1:0]        eff_len;
	logic                 eff_esc;
	logic                 eff_ovf;
	logic                 store_en;
	logic [7:0]           store_byte;
	wmm_pkg::kind_t       store_kind;
	logic                 esc_set;
	logic                 room;
	logic                 esc_next;
	logic [MAX_PATTERN:0] init_next;

	// name path
	logic                   start;
	logic [MAX_PATTERN-1:0] vmask;
	logic [MAX_PATTERN:0]   run_v;
	logic [MAX_PATTERN-1:0] hit_v;
	logic [MAX_PATTERN:0]   a_cur;
	logic [MAX_PATTERN:0]   adv;
	logic [MAX_PATTERN:0]   a0;
	logic [MAX_PATTERN:0]   gen_v;
	logic [MAX_PATTERN+1:0] csum;
	logic [MAX_PATTERN:0]   a_fin;
	logic                   had_n;
	logic                   match_n;

	assign res_item  = v_s1 & req_s1.func & req_s1.last;
	assign out_free  = ~out_v_q | rsp.ready;
	assign go        = v_s1 & (~res_item | out_free);
	assign req.ready = ~v_s1 | go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.func      <= req.func;
			req_s1.char_code <= req.char_code;
			req_s1.last      <= req.last;
			req_s1.no_char   <= req.no_char;
		end
	end

	// pattern load
	always_comb begin
		eff_len    = closed_q ? '0 : len_q;
		eff_esc    = closed_q ? 1'b0 : esc_q;
		eff_ovf    = closed_q ? 1'b0 : ovf_q;
		store_en   = 1'b0;
		store_byte = req_s1.char_code;
		store_kind = wmm_pkg::KIND_LITERAL;
		esc_set    = 1'b0;
		if (!req_s1.no_char) begin
			if (eff_esc) begin
				store_en = 1'b1;
			end else if (req_s1.char_code == wmm_pkg::CH_ESC) begin
				if (req_s1.last) begin
					store_en = 1'b1;
				end else begin
					esc_set = 1'b1;
				end
			end else if (req_s1.char_code == wmm_pkg::CH_STAR) begin
				store_en   = 1'b1;
				store_kind = wmm_pkg::KIND_ANY_RUN;
			end else if (req_s1.char_code == wmm_pkg::CH_QMARK) begin
				store_en   = 1'b1;
				store_kind = wmm_pkg::KIND_ANY_ONE;
			end else begin
				store_en = 1'b1;
			end
		end else if (req_s1.last && eff_esc) begin
			store_en   = 1'b1;
			store_byte = wmm_pkg::CH_ESC;
		end
		room     = eff_len < LW'(MAX_PATTERN);
		esc_next = ~req_s1.last & (esc_set | (req_s1.no_char & eff_esc));

		// start set of a name: every position reachable through leading '*'
		init_next = closed_q ? {{MAX_PATTERN{1'b0}}, 1'b1} : init_q;
		if (store_en && room) begin
			init_next[eff_len + LW'(1)] = init_next[eff_len] &
				(store_kind == wmm_pkg::KIND_ANY_RUN);
		end
	end

	// name step
	always_comb begin
		start = ~name_q;
		a_cur = start ? init_q : active_q;
		run_v = '0;
		adv   = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			vmask[i] = LW'(i) < len_q;
			run_v[i] = vmask[i] & (kind_q[i] == wmm_pkg::KIND_ANY_RUN);
			hit_v[i] = vmask[i] & ~run_v[i] &
				((kind_q[i] == wmm_pkg::KIND_ANY_ONE) ||
				 (byte_q[i] == req_s1.char_code));
		end
		for (int i = 0; i < MAX_PATTERN; i++) begin
			adv[i]   = adv[i] | (a_cur[i] & run_v[i]);
			adv[i+1] = a_cur[i] & hit_v[i];
		end
		a0 = req_s1.no_char ? a_cur : adv;

		// activity carries across '*' runs as an adder carry chain
		gen_v   = a0 & run_v;
		csum    = {1'b0, run_v} + {1'b0, gen_v};
		a_fin   = a0 | (csum[MAX_PATTERN:0] ^ run_v ^ gen_v);
		had_n   = (~start & had_q) | ~req_s1.no_char;
		match_n = ~ovf_q & a_fin[len_q] & (had_n | (len_q == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			esc_q    <= 1'b0;
			ovf_q    <= 1'b0;
			closed_q <= 1'b1;
			name_q   <= 1'b0;
			had_q    <= 1'b0;
			active_q <= {{MAX_PATTERN{1'b0}}, 1'b1};
			init_q   <= {{MAX_PATTERN{1'b0}}, 1'b1};
		end else if (go) begin
			if (!req_s1.func) begin
				len_q    <= (store_en && room) ? eff_len + LW'(1) : eff_len;
				ovf_q    <= eff_ovf | (store_en & ~room);
				esc_q    <= esc_next;
				closed_q <= req_s1.last;
				name_q   <= 1'b0;
				init_q   <= init_next;
			end else begin
				name_q   <= ~req_s1.last;
				had_q    <= had_n;
				active_q <= a_fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !req_s1.func && store_en && room) begin
			byte_q[eff_len[IW-1:0]] <= store_byte;
			kind_q[eff_len[IW-1:0]] <= store_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= go & res_item;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && go && res_item) begin
			out_q.matched       <= match_n;
			out_q.pattern_error <= ovf_q;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.matched       = out_q.matched;
	assign rsp.pattern_error = out_q.pattern_error;

endmodule
